// ===== src/fwsps_pkg.sv =====
// Package for the priority-sorted process queue.
// Holds the beat types and field widths shared by the queue RTL.
// No dependencies.
package fwsps_pkg;

  localparam int unsigned PID_W  = 8;
  localparam int unsigned PRIO_W = 7;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CYCLE = 2'd2,
    KIND_SORT  = 2'd3
  } kind_e;

  typedef logic [PID_W-1:0]  pid_t;
  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef struct packed {
    kind_e kind;
    pid_t  process_id;
    prio_t priority_req;
  } in_beat_t;

  typedef struct packed {
    pid_t   out_process_id;
    prio_t  out_priority;
    logic   present;
    logic   full_error;
    count_t count;
  } out_beat_t;

endpackage

// ===== src/fifo_with_stable_priority_sort_top.sv =====
// Top level of the priority-sorted process queue.
// Ring of DEPTH entries in one synchronous memory, with a small sequencer.
// Depends on fwsps_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_beat_i carries one command
//   beat: add to tail, pop head, cycle head to tail, or stable sort by
//   descending priority. Every command gives exactly one result beat on
//   out_valid_o / out_stall_i / out_beat_o, held in an output register.
//   Steps, accept to result valid: add goes straight to ST_RESP; pop and
//   cycle read the head from memory (registered read) and pass ST_POPD
//   first; sort runs an insertion sort through ST_KEY, ST_CMP and ST_PLACE
//   (one memory read and one write per step). Pop/cycle on an empty queue
//   and sort on fewer than two entries go straight to ST_RESP, as add does.
//   One command is in work at a time; the next is taken once the current
//   result sits in the output register, so no new command is accepted
//   while one is still in work.
//   Reset empties the queue (count and head cleared); memory contents are
//   not cleared and are never read before written.
//   While the receiver stalls, the result beat holds; one more command may
//   be accepted and worked, then its result waits until the output frees.
module fifo_with_stable_priority_sort_top #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned ID_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fwsps_pkg::in_beat_t  in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fwsps_pkg::out_beat_t out_beat_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned PW   = fwsps_pkg::PRIO_W;
  localparam int unsigned EW   = ID_BITS + PW;
  localparam int unsigned WB   = (ID_BITS > fwsps_pkg::PID_W) ? ID_BITS : fwsps_pkg::PID_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_POPD  = 3'd1;
  localparam logic [2:0] ST_RESP  = 3'd2;
  localparam logic [2:0] ST_KEY   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_PLACE = 3'd5;

  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [EW-1:0] slot_mem_q [DEPTH];
  logic [EW-1:0] rdata_q;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] i_nx;
  logic [EW-1:0] key_q, key_d;
  logic          cyc_q, cyc_d;
  logic [AW-1:0] cyc_addr_q, cyc_addr_d;
  fwsps_pkg::out_beat_t res_q, res_d;
  fwsps_pkg::out_beat_t out_beat_q, out_beat_d;
  logic          out_valid_q, out_valid_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;

  logic          in_acc;
  logic          out_free;
  logic [WB-1:0] rid_ext;
  logic [PW-1:0] rd_prio, key_prio;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  assign rid_ext  = WB'(rdata_q[EW-1:PW]);
  assign rd_prio  = rdata_q[PW-1:0];
  assign key_prio = key_q[PW-1:0];
  assign i_nx     = i_q + CW'(1);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    i_d        = i_q;
    j_d        = j_q;
    key_d      = key_q;
    cyc_d      = cyc_q;
    cyc_addr_d = cyc_addr_q;
    res_d      = res_q;
    out_beat_d = out_beat_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = ring_addr(head_q, j_q);
    mem_raddr  = head_q;
    mem_wdata  = key_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          state_d = ST_RESP;
          unique case (in_beat_i.kind) inside
            fwsps_pkg::KIND_ADD: begin
              if (count_q == CW'(DEPTH)) begin
                res_d.full_error = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ring_addr(head_q, count_q);
                mem_wdata = {ID_BITS'(in_beat_i.process_id), in_beat_i.priority_req};
                count_d   = count_q + CW'(1);
              end
            end
            fwsps_pkg::KIND_POP, fwsps_pkg::KIND_CYCLE: begin
              if (count_q != '0) begin
                mem_re     = 1'b1;
                mem_raddr  = head_q;
                head_d     = ring_addr(head_q, CW'(1));
                cyc_d      = (in_beat_i.kind == fwsps_pkg::KIND_CYCLE);
                cyc_addr_d = ring_addr(head_q, count_q);
                if (in_beat_i.kind == fwsps_pkg::KIND_POP) begin
                  count_d = count_q - CW'(1);
                end
                state_d = ST_POPD;
              end
            end
            default: begin
              if (count_q > CW'(1)) begin
                mem_re    = 1'b1;
                mem_raddr = ring_addr(head_q, CW'(1));
                i_d       = CW'(1);
                state_d   = ST_KEY;
              end
            end
          endcase
        end
      end
      ST_POPD: begin
        res_d.out_process_id = rid_ext[fwsps_pkg::PID_W-1:0];
        res_d.out_priority   = rd_prio;
        res_d.present        = 1'b1;
        if (cyc_q) begin
          mem_we    = 1'b1;
          mem_waddr = cyc_addr_q;
          mem_wdata = rdata_q;
        end
        state_d = ST_RESP;
      end
      ST_KEY: begin
        key_d     = rdata_q;
        j_d       = i_q;
        mem_re    = 1'b1;
        mem_raddr = ring_addr(head_q, i_q - CW'(1));
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        mem_we = 1'b1;
        if (rd_prio < key_prio) begin
          mem_wdata = rdata_q;
          j_d       = j_q - CW'(1);
          if (j_q > CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = ring_addr(head_q, j_q - CW'(2));
          end else begin
            state_d = ST_PLACE;
          end
        end else begin
          i_d = i_nx;
          if (i_nx < count_q) begin
            mem_re    = 1'b1;
            mem_raddr = ring_addr(head_q, i_nx);
            state_d   = ST_KEY;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_PLACE: begin
        mem_we = 1'b1;
        i_d    = i_nx;
        if (i_nx < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = ring_addr(head_q, i_nx);
          state_d   = ST_KEY;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_beat_d       = res_q;
          out_beat_d.count = fwsps_pkg::count_t'(count_q);
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= slot_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    key_q      <= key_d;
    cyc_q      <= cyc_d;
    cyc_addr_q <= cyc_addr_d;
    res_q      <= res_d;
    out_beat_q <= out_beat_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count above depth");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_free && res_q.full_error) |-> (count_q == CW'(DEPTH)))
    else $error("full reported below depth");

  a_sort_indices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP || state_q == ST_PLACE) |-> (j_q <= i_q && i_q < count_q))
    else $error("sort index out of range");

  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && count_q != '0 &&
     (in_beat_i.kind == fwsps_pkg::KIND_POP || in_beat_i.kind == fwsps_pkg::KIND_CYCLE))
    |=> (state_q == ST_POPD && head_q == ring_addr($past(head_q), CW'(1))))
    else $error("pop did not advance head");

endmodule
